[rtl/qvr_pkg.sv]
package qvr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FRAC_W = 30;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned RPROD_W = PROD_W - FRAC_W + 1;
	localparam int unsigned ENTRY_SUM_W = RPROD_W + 2;
	localparam int unsigned ACC_W = PROD_W + 2;
	localparam int unsigned RES_W = ACC_W - FRAC_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

	localparam logic signed [DATA_W-1:0] ONE_Q30 = DATA_W'(64'sd1 <<< FRAC_W);
	localparam logic signed [DATA_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
	localparam logic signed [PROD_W-1:0] HALF_PROD = PROD_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(64'sd2147483647);
	localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-64'sd2147483648);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_SCALAR = 2'd0,
		REG_QUAT_X      = 2'd1,
		REG_QUAT_Y      = 2'd2,
		REG_QUAT_Z      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic signed [DATA_W-1:0] rot_z;
		logic                     saturated;
	} out_item_t;

	function automatic logic signed [RPROD_W-1:0] rnd_mul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [PROD_W-1:0] p;
		logic signed [PROD_W-1:0] s;
		p = a * b;
		s = (p + HALF_PROD) >>> FRAC_W;
		return s[RPROD_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp_unit(
		input logic signed [ENTRY_SUM_W-1:0] m
	);
		logic signed [ENTRY_SUM_W-1:0] hi;
		logic signed [ENTRY_SUM_W-1:0] lo;
		hi = ENTRY_SUM_W'(ONE_Q30);
		lo = ENTRY_SUM_W'(NEG_ONE_Q30);
		if (m > hi) begin
			return ONE_Q30;
		end else if (m < lo) begin
			return NEG_ONE_Q30;
		end
		return m[DATA_W-1:0];
	endfunction

endpackage

[rtl/quaternion_vector_rotate_top.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    qvr_pkg::in_item_t  (vec_x, vec_y, vec_z)
// out       output     out_valid/out_ready  qvr_pkg::out_item_t (rot_x..rot_z, saturated)
// cfg       input      cfg_we               cfg_index, cfg_data (quaternion Q2.30)
//
// One item per cycle unless out_ready stalls or a configuration settles; out_valid
// rises once the item has passed four registers: input, 3x3 multiply, row sum and round, saturate.
// The matrix is built from the quaternion in two registered steps; in_ready
// stays low after reset and after each configuration write until the settle counter runs down.
// A stalled out_ready holds every stage; nothing is lost or repeated.
module quaternion_vector_rotate_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  qvr_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output qvr_pkg::out_item_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [qvr_pkg::DATA_W-1:0]           cfg_data
);

	logic signed [qvr_pkg::DATA_W-1:0] qa_q, qb_q, qc_q, qd_q;
	logic signed [qvr_pkg::RPROD_W-1:0] aa_q, bb_q, cc_q, dd_q, ab_q, ac_q, ad_q;
	logic signed [qvr_pkg::RPROD_W-1:0] bc_q, bd_q, cd_q;
	logic signed [qvr_pkg::ENTRY_SUM_W-1:0] raw_m [3][3];
	logic signed [qvr_pkg::DATA_W-1:0] m_q [3][3];
	logic [qvr_pkg::SETTLE_W-1:0] settle_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [qvr_pkg::DATA_W-1:0] vec_s1 [3];
	logic signed [qvr_pkg::PROD_W-1:0] prod_s2 [3][3];
	logic signed [qvr_pkg::RES_W-1:0] res_s3 [3];
	logic signed [qvr_pkg::RES_W-1:0] res_c [3];
	qvr_pkg::out_item_t out_s4;

	function automatic logic ovf(input logic signed [qvr_pkg::RES_W-1:0] r);
		return (r > qvr_pkg::RES_MAX) || (r < qvr_pkg::RES_MIN);
	endfunction

	function automatic logic signed [qvr_pkg::DATA_W-1:0] sat32(
		input logic signed [qvr_pkg::RES_W-1:0] r
	);
		logic signed [qvr_pkg::RES_W-1:0] t;
		t = r;
		if (r > qvr_pkg::RES_MAX) begin
			t = qvr_pkg::RES_MAX;
		end else if (r < qvr_pkg::RES_MIN) begin
			t = qvr_pkg::RES_MIN;
		end
		return t[qvr_pkg::DATA_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q     <= qvr_pkg::ONE_Q30;
			qb_q     <= '0;
			qc_q     <= '0;
			qd_q     <= '0;
			settle_q <= qvr_pkg::SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= qvr_pkg::SETTLE_CYCLES;
			case (qvr_pkg::cfg_reg_t'(cfg_index))
				qvr_pkg::REG_QUAT_SCALAR: qa_q <= cfg_data;
				qvr_pkg::REG_QUAT_X:      qb_q <= cfg_data;
				qvr_pkg::REG_QUAT_Y:      qc_q <= cfg_data;
				qvr_pkg::REG_QUAT_Z:      qd_q <= cfg_data;
				default: ;
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		aa_q <= qvr_pkg::rnd_mul(qa_q, qa_q);
		bb_q <= qvr_pkg::rnd_mul(qb_q, qb_q);
		cc_q <= qvr_pkg::rnd_mul(qc_q, qc_q);
		dd_q <= qvr_pkg::rnd_mul(qd_q, qd_q);
		ab_q <= qvr_pkg::rnd_mul(qa_q, qb_q);
		ac_q <= qvr_pkg::rnd_mul(qa_q, qc_q);
		ad_q <= qvr_pkg::rnd_mul(qa_q, qd_q);
		bc_q <= qvr_pkg::rnd_mul(qb_q, qc_q);
		bd_q <= qvr_pkg::rnd_mul(qb_q, qd_q);
		cd_q <= qvr_pkg::rnd_mul(qc_q, qd_q);
	end

	always_comb begin
		raw_m[0][0] = qvr_pkg::ENTRY_SUM_W'(aa_q) + qvr_pkg::ENTRY_SUM_W'(bb_q)
		            - qvr_pkg::ENTRY_SUM_W'(cc_q) - qvr_pkg::ENTRY_SUM_W'(dd_q);
		raw_m[1][1] = qvr_pkg::ENTRY_SUM_W'(aa_q) - qvr_pkg::ENTRY_SUM_W'(bb_q)
		            + qvr_pkg::ENTRY_SUM_W'(cc_q) - qvr_pkg::ENTRY_SUM_W'(dd_q);
		raw_m[2][2] = qvr_pkg::ENTRY_SUM_W'(aa_q) - qvr_pkg::ENTRY_SUM_W'(bb_q)
		            - qvr_pkg::ENTRY_SUM_W'(cc_q) + qvr_pkg::ENTRY_SUM_W'(dd_q);
		raw_m[0][1] = (qvr_pkg::ENTRY_SUM_W'(bc_q) - qvr_pkg::ENTRY_SUM_W'(ad_q)) <<< 1;
		raw_m[0][2] = (qvr_pkg::ENTRY_SUM_W'(bd_q) + qvr_pkg::ENTRY_SUM_W'(ac_q)) <<< 1;
		raw_m[1][0] = (qvr_pkg::ENTRY_SUM_W'(bc_q) + qvr_pkg::ENTRY_SUM_W'(ad_q)) <<< 1;
		raw_m[1][2] = (qvr_pkg::ENTRY_SUM_W'(cd_q) - qvr_pkg::ENTRY_SUM_W'(ab_q)) <<< 1;
		raw_m[2][0] = (qvr_pkg::ENTRY_SUM_W'(bd_q) - qvr_pkg::ENTRY_SUM_W'(ac_q)) <<< 1;
		raw_m[2][1] = (qvr_pkg::ENTRY_SUM_W'(cd_q) + qvr_pkg::ENTRY_SUM_W'(ab_q)) <<< 1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_q[i][j] <= qvr_pkg::clamp_unit(raw_m[i][j]);
			end
		end
	end

	assign adv      = !v_s4 || out_ready;
	assign in_ready = adv && (settle_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_c[i] = qvr_pkg::RES_W'((qvr_pkg::ACC_W'(prod_s2[i][0])
			         + qvr_pkg::ACC_W'(prod_s2[i][1])
			         + qvr_pkg::ACC_W'(prod_s2[i][2])
			         + qvr_pkg::HALF_ACC) >>> qvr_pkg::FRAC_W);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1[0] <= in_data.vec_x;
			vec_s1[1] <= in_data.vec_y;
			vec_s1[2] <= in_data.vec_z;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= m_q[i][j] * vec_s1[j];
				end
			end
			for (int i = 0; i < 3; i++) begin
				res_s3[i] <= res_c[i];
			end
			out_s4.rot_x     <= sat32(res_s3[0]);
			out_s4.rot_y     <= sat32(res_s3[1]);
			out_s4.rot_z     <= sat32(res_s3[2]);
			out_s4.saturated <= ovf(res_s3[0]) || ovf(res_s3[1]) || ovf(res_s3[2]);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule

[sim/qvr_rotation_checker.sv]
`timescale 1ns / 100ps

module qvr_rotation_checker
	import qvr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   results,
	output int                   clipped
);

	localparam longint HALF_LSB = 64'sd1 <<< 29;
	localparam longint UNIT = 64'sd1 <<< 30;
	localparam longint ROT_MAX = 64'sd2147483647;
	localparam longint ROT_MIN = -64'sd2147483648;

	out_item_t rotated_q [$];
	logic signed [DATA_W-1:0] quat_reg [4];
	int err_cnt;
	int res_cnt;
	int sat_cnt;

	function automatic longint round_prod(input longint a, input longint b);
		return (a * b + HALF_LSB) >>> 30;
	endfunction

	function automatic longint limit_entry(input longint m);
		if (m > UNIT) begin
			return UNIT;
		end else if (m < -UNIT) begin
			return -UNIT;
		end
		return m;
	endfunction

	function automatic out_item_t rotate_vector(
		input in_item_t v,
		input longint a,
		input longint b,
		input longint c,
		input longint d
	);
		longint aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
		longint m [3][3];
		longint vin [3];
		longint acc;
		longint r;
		logic signed [DATA_W-1:0] comp [3];
		out_item_t res;
		aa = round_prod(a, a);
		bb = round_prod(b, b);
		cc = round_prod(c, c);
		dd = round_prod(d, d);
		ab = round_prod(a, b);
		ac = round_prod(a, c);
		ad = round_prod(a, d);
		bc = round_prod(b, c);
		bd = round_prod(b, d);
		cd = round_prod(c, d);
		m[0][0] = limit_entry(aa + bb - cc - dd);
		m[0][1] = limit_entry(2 * (bc - ad));
		m[0][2] = limit_entry(2 * (bd + ac));
		m[1][0] = limit_entry(2 * (bc + ad));
		m[1][1] = limit_entry(aa - bb + cc - dd);
		m[1][2] = limit_entry(2 * (cd - ab));
		m[2][0] = limit_entry(2 * (bd - ac));
		m[2][1] = limit_entry(2 * (cd + ab));
		m[2][2] = limit_entry(aa - bb - cc + dd);
		vin[0] = longint'(v.vec_x);
		vin[1] = longint'(v.vec_y);
		vin[2] = longint'(v.vec_z);
		res.saturated = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * vin[0] + m[i][1] * vin[1] + m[i][2] * vin[2];
			r = (acc + HALF_LSB) >>> 30;
			if (r > ROT_MAX) begin
				r = ROT_MAX;
				res.saturated = 1'b1;
			end else if (r < ROT_MIN) begin
				r = ROT_MIN;
				res.saturated = 1'b1;
			end
			comp[i] = DATA_W'(r);
		end
		res.rot_x = comp[0];
		res.rot_y = comp[1];
		res.rot_z = comp[2];
		return res;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			rotated_q.delete();
			quat_reg[REG_QUAT_SCALAR] = ONE_Q30;
			quat_reg[REG_QUAT_X] = '0;
			quat_reg[REG_QUAT_Y] = '0;
			quat_reg[REG_QUAT_Z] = '0;
			err_cnt = 0;
			res_cnt = 0;
			sat_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$error("result item with nothing expected: x %0d y %0d z %0d sat %0b",
						out_data.rot_x, out_data.rot_y, out_data.rot_z, out_data.saturated);
					err_cnt++;
				end else begin
					want = rotated_q.pop_front();
					check_field("rot_x", want.rot_x, out_data.rot_x);
					check_field("rot_y", want.rot_y, out_data.rot_y);
					check_field("rot_z", want.rot_z, out_data.rot_z);
					check_field("saturated", want.saturated, out_data.saturated);
					res_cnt++;
					if (want.saturated) begin
						sat_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				rotated_q.push_back(rotate_vector(in_data,
					longint'(quat_reg[REG_QUAT_SCALAR]), longint'(quat_reg[REG_QUAT_X]),
					longint'(quat_reg[REG_QUAT_Y]), longint'(quat_reg[REG_QUAT_Z])));
			end
			if (cfg_we) begin
				quat_reg[cfg_index] = cfg_data;
			end
		end
		errors <= err_cnt;
		pending <= rotated_q.size();
		results <= res_cnt;
		clipped <= sat_cnt;
	end

endmodule

[sim/tb_quaternion_vector_rotate_top.sv]
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate_top;
	import qvr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 117;
	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] COS_EIGHTH = 32'sd992008094;
	localparam logic signed [DATA_W-1:0] SIN_EIGHTH = 32'sd410903207;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int results;
	int clipped;
	int send_idle_pct;
	int recv_idle_pct;
	int quat_loads;
	logic hold_req;

	always #5 clk = ~clk;

	quaternion_vector_rotate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qvr_rotation_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.results   (results),
		.clipped   (clipped)
	);

	function automatic logic signed [DATA_W-1:0] pick_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return DATA_W'($urandom_range(2000)) - 32'sd1000;
			2: begin
				case ($urandom_range(4))
					0: return VMAX;
					1: return VMIN;
					2: return '0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	function automatic void rand_unit_quat(output logic signed [DATA_W-1:0] q [4]);
		real r [4];
		real norm;
		norm = 0.0;
		for (int i = 0; i < 4; i++) begin
			r[i] = real'($urandom_range(2000)) - 1000.0;
			norm += r[i] * r[i];
		end
		if (norm < 1.0) begin
			r[0] = 1.0;
			norm = 1.0;
		end
		norm = $sqrt(norm);
		for (int i = 0; i < 4; i++) begin
			q[i] = DATA_W'($rtoi(r[i] / norm * 1073741824.0));
		end
	endfunction

	task automatic send_vec(input in_item_t v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_quat(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b,
		input logic signed [DATA_W-1:0] c,
		input logic signed [DATA_W-1:0] d
	);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_QUAT_SCALAR;
		cfg_data <= a;
		@(negedge clk);
		cfg_index <= REG_QUAT_X;
		cfg_data <= b;
		@(negedge clk);
		cfg_index <= REG_QUAT_Y;
		cfg_data <= c;
		@(negedge clk);
		cfg_index <= REG_QUAT_Z;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		quat_loads++;
	endtask

	initial begin : receiver
		int hold_left;
		logic hold_prev;
		hold_left = 0;
		hold_prev = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_prev) begin
				hold_left = HOLD_CYCLES;
			end
			hold_prev = hold_req;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic signed [DATA_W-1:0] q [4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_QUAT_SCALAR;
		cfg_data = '0;
		hold_req = 1'b0;
		quat_loads = 0;
		send_idle_pct = 28;
		recv_idle_pct = 49;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// identity after reset
		send_vec('{32'sd0, 32'sd0, 32'sd0});
		send_vec('{VMAX, VMIN, -32'sd1});
		send_vec('{VMIN, VMAX, 32'sd1});
		send_vec('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sd12345});

		// 45 degrees about z: large vectors clip
		load_quat(COS_EIGHTH, 32'sd0, 32'sd0, SIN_EIGHTH);
		send_vec('{VMAX, VMAX, VMAX});
		send_vec('{VMIN, VMIN, VMIN});
		send_vec('{VMAX, VMIN, 32'sd0});
		send_vec('{32'sd1 <<< 20, -(32'sd1 <<< 20), 32'sd3});

		// out-of-range quaternions: some matrix entries pin to +-1.0
		load_quat(VMAX, VMAX, VMAX, VMAX);
		send_vec('{VMAX, VMIN, VMAX});
		send_vec('{32'sd1000, -32'sd7, 32'sd1});
		load_quat(VMIN, VMIN, VMIN, VMIN);
		send_vec('{VMIN, VMIN, VMAX});
		send_vec('{-32'sd1, 32'sd1, -32'sd1});

		load_quat(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_vec('{VMAX, VMIN, VMAX});
		send_vec('{32'sd5, 32'sd6, 32'sd7});

		// half turn about x
		load_quat(32'sd0, ONE_Q30, 32'sd0, 32'sd0);
		send_vec('{VMIN, VMIN, VMIN});
		send_vec('{VMAX, 32'sd1, -32'sd1});

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 1) begin
				q[0] = $urandom;
				q[1] = $urandom;
				q[2] = $urandom;
				q[3] = $urandom;
			end else begin
				rand_unit_quat(q);
			end
			load_quat(q[0], q[1], q[2], q[3]);
			if (phase == 2) begin
				send_idle_pct = 49;
				recv_idle_pct = 28;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				@(negedge clk);
				hold_req <= 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				send_vec('{pick_comp(), pick_comp(), pick_comp()});
			end
		end

		drain();
		$display("rotated %0d vectors under %0d quaternion loads, %0d results clipped",
			results, quat_loads, clipped);
		$display("input backed up behind one %0d-cycle output hold", HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
